/* hdl/tlnef_pkg.sv */
// ----------------------------------------------------------------------------
// tlnef_pkg: shared types and constants for the text line filter
// Transfer payload structs, option bit positions and character codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tlnef_pkg;

  // default number of decimal places in the line number
  localparam int unsigned NumberDigitsDefault = 6;

  // option register
  localparam int unsigned OptWidth        = 6;
  localparam int unsigned OptNumNonblank  = 0;
  localparam int unsigned OptShowEnds     = 1;
  localparam int unsigned OptNumAll       = 2;
  localparam int unsigned OptSqueeze      = 3;
  localparam int unsigned OptTabCaret     = 4;
  localparam int unsigned OptCtrlCaret    = 5;

  // character codes
  localparam logic [7:0] ChrTab     = 8'd9;
  localparam logic [7:0] ChrNewline = 8'd10;
  localparam logic [7:0] ChrSpace   = 8'd32;
  localparam logic [7:0] ChrDollar  = 8'd36;
  localparam logic [7:0] ChrZero    = 8'd48;
  localparam logic [7:0] ChrCaret   = 8'd94;
  localparam logic [7:0] ChrLetterI = 8'd73;
  localparam logic [7:0] ChrQuery   = 8'd63;
  localparam logic [7:0] ChrDelete  = 8'd127;
  localparam logic [7:0] ChrCtrlMax = 8'd31;
  localparam logic [7:0] CaretShift = 8'd64;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_file;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

endpackage

`default_nettype wire

/* hdl/text_line_number_escape_filter.sv */
// ----------------------------------------------------------------------------
// text_line_number_escape_filter
// Byte-stream text filter with line numbering, blank-line squeezing and
// caret display of control bytes.
// ----------------------------------------------------------------------------
// Usage
//   in channel  : in_valid_i / in_ready_o carry one raw byte and a new-file
//                 flag per transfer
//   out channel : out_valid_o / out_ready_i carry one output character per
//                 transfer; last_of_run marks the final character of an input
//   option word : cfg_we_i writes cfg_wdata_i; the user must write it only
//                 while idle, as the block itself does not enforce this
// Path: the first character of an input passes the job register, then the
//   output register, before it appears on out_valid_o. An input gives 0 to
//   NUMBER_DIGITS+3 characters, one per cycle while out_ready_i is high, set
//   by the single output register draining the job register slot by slot.
// Throughput: 1 input per cycle while each input yields one character and
//   out_ready_i is high; an input that yields more holds the job register,
//   and the next input is taken in the cycle its predecessor's last character
//   is loaded. A squeezed newline is absorbed in its transfer cycle.
// Reset: line counter 1, history newline then zero, options 0, both
//   registers empty.
// Stall: when out_ready_i is low the output register holds its character
//   and the job register waits, so in_ready_o drops once both are occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module text_line_number_escape_filter
  import tlnef_pkg::*;
#(
  parameter int unsigned NUMBER_DIGITS = NumberDigitsDefault
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output out_item_t            out_data_o,
  input  wire                  cfg_we_i,
  input  wire [OptWidth-1:0]   cfg_wdata_i
);

  localparam int unsigned CntW      = 4 * NUMBER_DIGITS;
  // emission slots: digits (most significant first), tab, dollar, caret, char
  localparam int unsigned SlotTab   = NUMBER_DIGITS;
  localparam int unsigned SlotDol   = NUMBER_DIGITS + 1;
  localparam int unsigned SlotCaret = NUMBER_DIGITS + 2;
  localparam int unsigned SlotChar  = NUMBER_DIGITS + 3;
  localparam int unsigned Slots     = NUMBER_DIGITS + 4;

  // options and line history
  logic [OptWidth-1:0] opt_q;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [7:0]          prev_q, prev2_q;

  // job register: one accepted item waiting to be spelt out
  logic               job_valid_q, job_valid_d;
  logic [Slots-1:0]   job_mask_q, job_mask_d;
  logic [7:0]         job_digit_q [NUMBER_DIGITS];
  logic [7:0]         job_char_q;

  // output register
  logic       out_valid_q;
  out_item_t  out_q;

  // handshake terms
  logic in_xfer, out_free, emit, emit_last;

  // ---------------------------------------------------------------------------
  // decode of the incoming byte against the current history
  // ---------------------------------------------------------------------------
  logic [7:0]      c, prev_e, prev2_e;
  logic [CntW-1:0] cnt_e;
  logic            squeezed, number, dollar, caret;
  logic [7:0]      char_byte;
  logic [Slots-1:0] new_mask;
  logic [7:0]      digit_chr [NUMBER_DIGITS];
  logic            all_nines;
  logic [CntW-1:0] cnt_inc;

  always_comb begin
    logic       nz_above;
    logic       carry;
    logic [3:0] d;
    c       = in_data_i.data_byte;
    // a new file restarts numbering and forgets line history
    prev_e  = in_data_i.new_file ? ChrNewline : prev_q;
    prev2_e = in_data_i.new_file ? 8'd0 : prev2_q;
    cnt_e   = in_data_i.new_file ? CntW'(1) : cnt_q;

    squeezed = opt_q[OptSqueeze] && prev2_e == ChrNewline &&
               prev_e == ChrNewline && c == ChrNewline;

    if (prev_e != ChrNewline) begin
      number = 1'b0;
    end else if (opt_q[OptNumNonblank]) begin
      number = (c != ChrNewline);
    end else begin
      number = opt_q[OptNumAll];
    end
    dollar = opt_q[OptShowEnds] && c == ChrNewline;

    // tab caret takes priority, then control bytes, then delete
    if (opt_q[OptTabCaret] && c == ChrTab) begin
      caret     = 1'b1;
      char_byte = ChrLetterI;
    end else if (opt_q[OptCtrlCaret] && c <= ChrCtrlMax && c != ChrTab &&
                 c != ChrNewline) begin
      caret     = 1'b1;
      char_byte = c + CaretShift;
    end else if (opt_q[OptCtrlCaret] && c == ChrDelete) begin
      caret     = 1'b1;
      char_byte = ChrQuery;
    end else begin
      caret     = 1'b0;
      char_byte = c;
    end

    // digit characters, leading zeros blanked, last digit always shown
    nz_above = 1'b0;
    for (int k = 0; k < NUMBER_DIGITS; k++) begin
      d = cnt_e[4*(NUMBER_DIGITS-1-k) +: 4];
      if (d > 4'd9) begin
        d = 4'd9;
      end
      if (!nz_above && d == 4'd0 && k != NUMBER_DIGITS - 1) begin
        digit_chr[k] = ChrSpace;
      end else begin
        digit_chr[k] = ChrZero + {4'd0, d};
      end
      nz_above = nz_above || (d != 4'd0);
    end

    // saturating bcd increment
    all_nines = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (cnt_e[4*i +: 4] != 4'd9) begin
        all_nines = 1'b0;
      end
    end
    carry   = 1'b1;
    cnt_inc = cnt_e;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (carry) begin
        if (cnt_e[4*i +: 4] >= 4'd9) begin
          cnt_inc[4*i +: 4] = 4'd0;
        end else begin
          cnt_inc[4*i +: 4] = cnt_e[4*i +: 4] + 4'd1;
          carry = 1'b0;
        end
      end
    end

    new_mask            = '0;
    new_mask[SlotTab]   = number;
    new_mask[SlotDol]   = dollar;
    new_mask[SlotCaret] = caret;
    new_mask[SlotChar]  = 1'b1;
    for (int k = 0; k < NUMBER_DIGITS; k++) begin
      new_mask[k] = number;
    end
  end

  // ---------------------------------------------------------------------------
  // slot selection: lowest pending slot goes out next
  // ---------------------------------------------------------------------------
  logic [Slots-1:0] pick, rest;
  logic [7:0]       slot_byte [Slots];
  logic [7:0]       emit_byte;

  always_comb begin
    for (int k = 0; k < NUMBER_DIGITS; k++) begin
      slot_byte[k] = job_digit_q[k];
    end
    slot_byte[SlotTab]   = ChrTab;
    slot_byte[SlotDol]   = ChrDollar;
    slot_byte[SlotCaret] = ChrCaret;
    slot_byte[SlotChar]  = job_char_q;

    pick = job_mask_q & (~job_mask_q + Slots'(1));
    rest = job_mask_q & ~pick;
    emit_byte = '0;
    for (int s = 0; s < Slots; s++) begin
      emit_byte = emit_byte | (pick[s] ? slot_byte[s] : 8'd0);
    end
  end

  // output register is free when empty or being taken this cycle
  assign out_free   = !out_valid_q || out_ready_i;
  assign emit       = job_valid_q && out_free;
  assign emit_last  = emit && rest == '0;
  assign in_ready_o = !job_valid_q || emit_last;
  assign in_xfer    = in_valid_i && in_ready_o;

  // squeezed newlines never occupy the job register
  always_comb begin
    job_valid_d = job_valid_q;
    job_mask_d  = job_mask_q;
    if (emit) begin
      job_mask_d  = rest;
      job_valid_d = rest != '0;
    end
    if (in_xfer && !squeezed) begin
      job_valid_d = 1'b1;
      job_mask_d  = new_mask;
    end
  end

  // counter advances only when a number is printed
  always_comb begin
    cnt_d = cnt_q;
    if (in_xfer) begin
      if (!squeezed && number && !all_nines) begin
        cnt_d = cnt_inc;
      end else begin
        cnt_d = cnt_e;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opt_q       <= '0;
      cnt_q       <= CntW'(1);
      prev_q      <= ChrNewline;
      prev2_q     <= 8'd0;
      job_valid_q <= 1'b0;
      job_mask_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        opt_q <= cfg_wdata_i;
      end
      cnt_q       <= cnt_d;
      job_valid_q <= job_valid_d;
      job_mask_q  <= job_mask_d;
      if (in_xfer) begin
        // history shifts even for a squeezed newline
        prev2_q <= prev_e;
        prev_q  <= c;
      end
      if (out_free) begin
        out_valid_q <= emit;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer && !squeezed) begin
      job_digit_q <= digit_chr;
      job_char_q  <= char_byte;
    end
    if (emit) begin
      out_q.out_byte    <= emit_byte;
      out_q.last_of_run <= rest == '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_job_has_slots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> job_mask_q != '0)
    else $error("job register valid with no pending slot");

  a_job_char_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> job_mask_q[SlotChar])
    else $error("job lost its data character before the end");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_valid_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while job and output are both stalled");

  a_load_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !squeezed) |=> job_valid_q)
    else $error("accepted item did not reach the job register");

  a_last_clears_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_last && !in_xfer) |=> !job_valid_q)
    else $error("job register still busy after its last character");

endmodule

`default_nettype wire
